/* src/rbf_pkg.sv */
// rbf_pkg: shared types and constants of the rgb 3x3 box filter
// no dependencies; imported by every other file of the block
`default_nettype none

package rbf_pkg;

   // default line store depth, largest usable frame width
   localparam int MAX_WIDTH_DEF = 1024;

   // pixel layout
   localparam int CHAN_W     = 8;
   localparam int CHAN_COUNT = 3;
   localparam int CHAN_RED   = 2;
   localparam int CHAN_GREEN = 1;
   localparam int CHAN_BLUE  = 0;

   // configuration registers
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 12;
   localparam int CSR_DATA_W   = 12;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_RESET = 480;
   localparam int MIN_SIZE     = 3;

   // position counters
   localparam int ROW_W   = CFG_HEIGHT_W + 1;
   localparam int COUNT_W = CFG_WIDTH_W + CFG_HEIGHT_W;

   // item kinds
   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_FLUSH = 1'b1;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   typedef logic [CHAN_COUNT-1:0][CHAN_W-1:0] pixel_type;

   // what the back end has to do with one queued item
   typedef struct packed {
      logic wr;         // pixel: write the line stores, bottom row is the pixel
      logic rd;         // read the line stores, else zeros enter the window
      logic emit;       // item gives a result
      logic filter;     // result is the mean, else the window centre
      logic frame_end;  // last result of the frame
   } item_ctrl_type;

   localparam int CTRL_W = $bits(item_ctrl_type);

endpackage

`default_nettype wire

/* src/rbf_stream_if.sv */
// rbf_req_if, rbf_rsp_if: valid/ready channels of the box filter
// depends on rbf_pkg for the channel width
`default_nettype none

interface rbf_req_if import rbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              action;
   logic [CHAN_W-1:0] red_in;
   logic [CHAN_W-1:0] green_in;
   logic [CHAN_W-1:0] blue_in;

   modport source (output valid, action, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, action, red_in, green_in, blue_in, output ready);
endinterface

interface rbf_rsp_if import rbf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red_out;
   logic [CHAN_W-1:0] green_out;
   logic [CHAN_W-1:0] blue_out;
   logic              frame_end;

   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

/* src/rbf_front.sv */
// rbf_front: size registers, raster position counters and item classification
// depends on rbf_pkg; feeds rbf_queue
`default_nettype none

module rbf_front import rbf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int ADDR_W    = 10
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                   item_valid,
   output logic                        item_ready,
   input  wire logic                   item_action,
   input  wire pixel_type              item_pixel,
   input  wire logic                   queue_full,
   output logic                        push_valid,
   output item_ctrl_type               push_ctrl,
   output logic [ADDR_W-1:0]           push_addr,
   output pixel_type                   push_pixel
);

   localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam logic [CFG_WIDTH_W-1:0]  RESET_W_VAL = CFG_WIDTH_W'(RESET_W);
   localparam logic [CFG_HEIGHT_W-1:0] RESET_H_VAL = CFG_HEIGHT_W'(HEIGHT_RESET);
   localparam logic [COUNT_W-1:0]      AREA_RESET  = COUNT_W'(RESET_W * HEIGHT_RESET);
   localparam logic [31:0]             MAX_W32     = 32'(MAX_WIDTH);

   function automatic logic [CFG_WIDTH_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
      logic [CFG_WIDTH_W-1:0] r;
      if (v < CFG_WIDTH_W'(MIN_SIZE)) begin
         r = CFG_WIDTH_W'(MIN_SIZE);
      end else if (32'(v) > MAX_W32) begin
         r = CFG_WIDTH_W'(MAX_WIDTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CFG_HEIGHT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] v);
      return (v < CFG_HEIGHT_W'(MIN_SIZE)) ? CFG_HEIGHT_W'(MIN_SIZE) : v;
   endfunction

   // effective sizes and their product
   logic [CFG_WIDTH_W-1:0]  width_ff, width_in;
   logic [CFG_HEIGHT_W-1:0] height_ff, height_in;
   logic [COUNT_W-1:0]      area_ff, area_in;
   logic                    wr_width, wr_height;

   // raster position of the next pixel, results given in this frame
   logic [CFG_WIDTH_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic                    accept;
   logic                    wrap;
   logic [CFG_WIDTH_W-1:0]  pix_col;
   logic [ROW_W-1:0]        pix_row;
   logic [ROW_W-1:0]        pix_row_inc;
   logic [CFG_WIDTH_W:0]    col_next_wide;
   logic                    last_col;
   logic                    in_frame;
   logic                    pix_emit;
   logic                    pix_filter;
   logic                    frame_done;
   logic [COUNT_W-1:0]      count_inc;
   logic                    flush_end;
   logic [CFG_WIDTH_W-1:0]  col_sat;

   // size writes: product formed from the value being written so it is never stale
   assign wr_width  = csr_we && (csr_index == CSR_FRAME_WIDTH);
   assign wr_height = csr_we && (csr_index == CSR_FRAME_HEIGHT);
   assign width_in  = wr_width ? clamp_width(csr_wdata[CFG_WIDTH_W-1:0]) : width_ff;
   assign height_in = wr_height ? clamp_height(csr_wdata[CFG_HEIGHT_W-1:0]) : height_ff;
   assign area_in   = COUNT_W'(width_in) * COUNT_W'(height_in);

   assign item_ready = !queue_full;
   assign accept     = item_valid && item_ready;

   // pixel: a column at or past the width starts the next row
   assign wrap          = col_ff >= width_ff;
   assign pix_col       = wrap ? '0 : col_ff;
   assign pix_row       = wrap ? row_ff + ROW_W'(1) : row_ff;
   assign pix_row_inc   = pix_row + ROW_W'(1);
   assign in_frame      = pix_row < ROW_W'(height_ff);
   assign col_next_wide = {1'b0, pix_col} + (CFG_WIDTH_W + 1)'(1);
   assign last_col      = col_next_wide >= {1'b0, width_ff};
   assign pix_emit      = (pix_row >= ROW_W'(2)) ||
                          ((pix_row == ROW_W'(1)) && (pix_col >= CFG_WIDTH_W'(1)));
   assign pix_filter    = (pix_col >= CFG_WIDTH_W'(2)) && (pix_row >= ROW_W'(2));

   // flush: only once all rows are in
   assign frame_done = row_ff >= ROW_W'(height_ff);
   assign count_inc  = count_ff + COUNT_W'(1);
   assign flush_end  = count_inc >= area_ff;
   assign col_sat    = (&col_ff) ? col_ff : col_ff + CFG_WIDTH_W'(1);

   always_comb begin
      col_in     = col_ff;
      row_in     = row_ff;
      count_in   = count_ff;
      push_valid = 1'b0;
      push_ctrl  = '0;
      push_addr  = ADDR_W'(pix_col);
      push_pixel = item_pixel;
      if (accept) begin
         case (item_action)
            ACTION_PIXEL: begin
               if (!in_frame) begin
                  col_in = pix_col;
                  row_in = pix_row;
               end else begin
                  push_valid       = 1'b1;
                  push_ctrl.wr     = 1'b1;
                  push_ctrl.rd     = 1'b1;
                  push_ctrl.emit   = pix_emit;
                  push_ctrl.filter = pix_filter;
                  if (last_col) begin
                     col_in = '0;
                     row_in = pix_row_inc;
                  end else begin
                     col_in = col_next_wide[CFG_WIDTH_W-1:0];
                     row_in = pix_row;
                  end
                  if (pix_emit) begin
                     count_in = count_inc;
                  end
               end
            end
            ACTION_FLUSH: begin
               push_addr = ADDR_W'(col_ff);
               if (frame_done) begin
                  push_valid          = 1'b1;
                  push_ctrl.rd        = col_ff < width_ff;
                  push_ctrl.emit      = 1'b1;
                  push_ctrl.frame_end = flush_end;
                  if (flush_end) begin
                     col_in   = '0;
                     row_in   = '0;
                     count_in = '0;
                  end else begin
                     col_in   = col_sat;
                     count_in = count_inc;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_W_VAL;
         height_ff <= RESET_H_VAL;
         area_ff   <= AREA_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         count_ff  <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         area_ff   <= area_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

/* src/rbf_queue.sv */
// rbf_queue: short first-in first-out queue between front and back
// depends on rbf_pkg for the default depth
`default_nettype none

module rbf_queue import rbf_pkg::*; #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      head_data,
   output logic                   empty,
   output logic                   full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign empty     = count_ff == '0;
   assign full      = count_ff == DEPTH_CNT;
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* src/rbf_back.sv */
// rbf_back: line stores, sliding window, 3x3 mean and result register
// depends on rbf_pkg; takes items from rbf_queue
`default_nettype none

module rbf_back import rbf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF,
   parameter int ADDR_W    = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              head_valid,
   input  wire item_ctrl_type     head_ctrl,
   input  wire logic [ADDR_W-1:0] head_addr,
   input  wire pixel_type         head_pixel,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output pixel_type              out_pixel,
   output logic                   out_frame_end
);

   localparam int COLSUM_W = CHAN_W + 2;
   localparam int SUM_W    = CHAN_W + 4;
   localparam int RECIP_W  = 12;
   localparam int PROD_W   = SUM_W + RECIP_W;
   localparam int RECIP    = 3641;   // ceil(2^15 / 9), exact for sums below 2^15
   localparam int SHIFT    = 15;

   // (sum + 4) / 9 as multiply by reciprocal
   function automatic logic [CHAN_W-1:0] mean9(input logic [SUM_W-1:0] s);
      logic [PROD_W-1:0] p;
      p = PROD_W'(s + SUM_W'(4)) * PROD_W'(RECIP);
      return p[SHIFT +: CHAN_W];
   endfunction

   pixel_type upper_mem  [MAX_WIDTH];
   pixel_type middle_mem [MAX_WIDTH];

   logic                  adv;

   // stage 1: store read data arrives
   logic                  s1_valid_ff;
   item_ctrl_type         s1_ctrl_ff;
   logic [ADDR_W-1:0]     s1_addr_ff;
   pixel_type             s1_pixel_ff;
   pixel_type             up_rd_ff;
   pixel_type             mid_rd_ff;

   // window kept as column sums plus the middle pixel of the newest column
   logic [COLSUM_W-1:0]   cs1_ff [CHAN_COUNT];
   logic [COLSUM_W-1:0]   cs2_ff [CHAN_COUNT];
   pixel_type             mid2_ff;

   pixel_type             top_px, mid_px, bot_px;
   logic [COLSUM_W-1:0]   new_cs  [CHAN_COUNT];
   logic [SUM_W-1:0]      win_sum [CHAN_COUNT];

   // stage 2: sums ready for the divide
   logic                  s2_valid_ff;
   logic [SUM_W-1:0]      s2_sum_ff [CHAN_COUNT];
   pixel_type             s2_center_ff;
   logic                  s2_filter_ff;
   logic                  s2_end_ff;

   // result register
   logic                  out_valid_ff;
   pixel_type             out_pixel_ff;
   logic                  out_end_ff;
   pixel_type             mean_px;

   assign adv = !out_valid_ff || out_ready;
   assign pop = adv && head_valid;

   assign top_px = s1_ctrl_ff.rd ? up_rd_ff : '0;
   assign mid_px = s1_ctrl_ff.rd ? mid_rd_ff : '0;
   assign bot_px = s1_ctrl_ff.wr ? s1_pixel_ff : '0;

   always_comb begin
      for (int ch = 0; ch < CHAN_COUNT; ch++) begin
         new_cs[ch]  = COLSUM_W'(top_px[ch]) + COLSUM_W'(mid_px[ch]) + COLSUM_W'(bot_px[ch]);
         win_sum[ch] = SUM_W'(cs1_ff[ch]) + SUM_W'(cs2_ff[ch]) + SUM_W'(new_cs[ch]);
         mean_px[ch] = mean9(s2_sum_ff[ch]);
      end
   end

   // line stores: read for the item entering, write back for the item in stage 1
   always_ff @(posedge clock) begin
      if (pop && head_ctrl.rd) begin
         up_rd_ff  <= upper_mem[head_addr];
         mid_rd_ff <= middle_mem[head_addr];
      end
      if (adv && s1_valid_ff && s1_ctrl_ff.wr) begin
         upper_mem[s1_addr_ff]  <= mid_rd_ff;
         middle_mem[s1_addr_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mid2_ff      <= '0;
         for (int ch = 0; ch < CHAN_COUNT; ch++) begin
            cs1_ff[ch] <= '0;
            cs2_ff[ch] <= '0;
         end
      end else if (adv) begin
         s1_valid_ff  <= pop;
         s2_valid_ff  <= s1_valid_ff && s1_ctrl_ff.emit;
         out_valid_ff <= s2_valid_ff;
         if (s1_valid_ff) begin
            mid2_ff <= mid_px;
            for (int ch = 0; ch < CHAN_COUNT; ch++) begin
               cs1_ff[ch] <= cs2_ff[ch];
               cs2_ff[ch] <= new_cs[ch];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ctrl_ff  <= head_ctrl;
         s1_addr_ff  <= head_addr;
         s1_pixel_ff <= head_pixel;
      end
      if (adv && s1_valid_ff) begin
         s2_center_ff <= mid2_ff;
         s2_filter_ff <= s1_ctrl_ff.filter;
         s2_end_ff    <= s1_ctrl_ff.frame_end;
         for (int ch = 0; ch < CHAN_COUNT; ch++) begin
            s2_sum_ff[ch] <= win_sum[ch];
         end
      end
      if (adv && s2_valid_ff) begin
         out_pixel_ff <= s2_filter_ff ? mean_px : s2_center_ff;
         out_end_ff   <= s2_end_ff;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_pixel     = out_pixel_ff;
   assign out_frame_end = out_end_ff;

endmodule

`default_nettype wire

/* src/rgb_box_filter_3x3_core.sv */
// rgb_box_filter_3x3_core: top level of the streaming 3x3 rgb box filter
// depends on rbf_pkg, rbf_stream_if, rbf_front, rbf_queue and rbf_back
`default_nettype none

// Streaming 3x3 mean filter for 8-bit rgb pixels in raster order. Each interior
// pixel becomes (sum + 4) / 9 of its unfiltered 3x3 neighbourhood per channel;
// the first and last rows and columns pass through unchanged. Results trail the
// input by one line plus one pixel, so after the last pixel of a frame send
// frame_width + 1 flush items (action = 1); the last result carries frame_end.
// Pixels past the end of the frame and flushes before it are taken and dropped.
// Throughput is one item per clock: a new item is taken every cycle while the
// four-entry queue has room, and the back end advances whenever the result
// register is empty or being taken. An item reaches rsp valid via the queue, the
// line store read and the window sum; the divide feeds the result register. The
// two line stores (MAX_WIDTH pixels each) are read for one item and written back
// for the one before it in the same cycle; they have no reset and need no
// clearing pass. frame_width (index 0) and frame_height (index 1) are written
// through the csr port; the user must write them while no item is in flight; the
// block does not enforce it. A width write uses its low 11 bits; a width below 3
// acts as 3, above MAX_WIDTH as MAX_WIDTH, and a height below 3 as 3.
module rgb_box_filter_3x3_core import rbf_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   rbf_req_if.sink                     req_chan,
   rbf_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   // line store address bits
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int ITEM_W = CTRL_W + ADDR_W + $bits(pixel_type);

   pixel_type         req_pixel;

   // front to queue
   logic              push_valid;
   item_ctrl_type     push_ctrl;
   logic [ADDR_W-1:0] push_addr;
   pixel_type         push_pixel;
   logic              q_full;
   logic              q_empty;
   logic [ITEM_W-1:0] q_head;

   // queue to back
   item_ctrl_type     head_ctrl;
   logic [ADDR_W-1:0] head_addr;
   pixel_type         head_pixel;
   logic              pop;

   pixel_type         rsp_pixel;

   assign req_pixel[CHAN_RED]   = req_chan.red_in;
   assign req_pixel[CHAN_GREEN] = req_chan.green_in;
   assign req_pixel[CHAN_BLUE]  = req_chan.blue_in;

   // sizes, position counters and the choice of what each item does
   rbf_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_valid  (req_chan.valid),
      .item_ready  (req_chan.ready),
      .item_action (req_chan.action),
      .item_pixel  (req_pixel),
      .queue_full  (q_full),
      .push_valid  (push_valid),
      .push_ctrl   (push_ctrl),
      .push_addr   (push_addr),
      .push_pixel  (push_pixel)
   );

   // decouples the input handshake from output back-pressure
   rbf_queue #(
      .DATA_W (ITEM_W),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_ctrl, push_addr, push_pixel}),
      .pop       (pop),
      .head_data (q_head),
      .empty     (q_empty),
      .full      (q_full)
   );

   assign {head_ctrl, head_addr, head_pixel} = q_head;

   // line stores, window and mean
   rbf_back #(
      .MAX_WIDTH (MAX_WIDTH),
      .ADDR_W    (ADDR_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (!q_empty),
      .head_ctrl     (head_ctrl),
      .head_addr     (head_addr),
      .head_pixel    (head_pixel),
      .pop           (pop),
      .out_valid     (rsp_chan.valid),
      .out_ready     (rsp_chan.ready),
      .out_pixel     (rsp_pixel),
      .out_frame_end (rsp_chan.frame_end)
   );

   assign rsp_chan.red_out   = rsp_pixel[CHAN_RED];
   assign rsp_chan.green_out = rsp_pixel[CHAN_GREEN];
   assign rsp_chan.blue_out  = rsp_pixel[CHAN_BLUE];

endmodule

`default_nettype wire
